>>> rtl/utf8_bidi_embedding_checker_top_assert.svh
// Assertion macros for the bidi embedding checker top level.
`ifndef UTF8_BIDI_EMBEDDING_CHECKER_TOP_ASSERT_SVH
`define UTF8_BIDI_EMBEDDING_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UBEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UBEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ubec_pkg.sv
// Package: types, constants and helpers shared by the bidi checker modules.
package ubec_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [20:0] CP_LRE = 21'h202A;
  localparam logic [20:0] CP_RLE = 21'h202B;
  localparam logic [20:0] CP_PDF = 21'h202C;
  localparam logic [20:0] CP_LRO = 21'h202D;
  localparam logic [20:0] CP_RLO = 21'h202E;
  localparam logic [20:0] CP_LRI = 21'h2066;
  localparam logic [20:0] CP_RLI = 21'h2067;
  localparam logic [20:0] CP_FSI = 21'h2068;
  localparam logic [20:0] CP_PDI = 21'h2069;
  localparam logic [20:0] CP_PSEP = 21'h2029;

  localparam logic [7:0] SEP_LO = 8'h1C;
  localparam logic [7:0] SEP_HI = 8'h1F;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_PDF,
    OP_PUSH_PDI,
    OP_POP_PDF,
    OP_POP_PDI,
    OP_CLEAR
  } stack_op_t;

  typedef enum logic [2:0] {
    TR_ANY,
    TR_A0_BF,
    TR_80_9F,
    TR_90_BF,
    TR_80_8F
  } trail_rule_t;

  typedef struct packed {
    stack_op_t op;
    logic      last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0] ctx_cnt;
    logic [CNT_W-1:0] pdi_cnt;
  } stk_stat_t;

  function automatic stack_op_t classify_cp(input logic [20:0] cp);
    stack_op_t op;
    op = OP_NONE;
    if (cp == CP_RLO || cp == CP_RLE || cp == CP_LRO || cp == CP_LRE) begin
      op = OP_PUSH_PDF;
    end else if (cp == CP_PDF) begin
      op = OP_POP_PDF;
    end else if (cp == CP_RLI || cp == CP_LRI || cp == CP_FSI) begin
      op = OP_PUSH_PDI;
    end else if (cp == CP_PDI) begin
      op = OP_POP_PDI;
    end else if (cp == CP_PSEP) begin
      op = OP_CLEAR;
    end
    return op;
  endfunction

endpackage

>>> rtl/ubec_if.sv
// Channel interfaces: byte input and result output.
interface ubec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_buffer;

  modport source (output valid, output text_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input text_byte, input end_of_buffer, output ready);
endinterface

interface ubec_out_if;
  logic valid;
  logic ready;
  logic unclosed_context;
  logic stack_overflowed;

  modport source (output valid, output unclosed_context, output stack_overflowed,
                  input ready);
  modport sink   (input valid, input unclosed_context, input stack_overflowed,
                  output ready);
endinterface

>>> rtl/ubec_decoder.sv
// Front end: strict UTF-8 decoder that turns bytes into stack operations.
module ubec_decoder
  import ubec_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  ubec_in_if.sink        in_ch,
  input  q_stat_t        q_stat,
  output logic           q_push,
  output q_entry_t       q_entry
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] part_r, part_nxt;
  trail_rule_t rule_r, rule_nxt;
  stack_op_t   op;
  logic        trail_ok;
  logic        accept;
  logic [7:0]  b;
  logic [20:0] cp_ext;

  assign b           = in_ch.text_byte;
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cp_ext      = {part_r[14:0], b[5:0]};

  always_comb begin
    trail_ok = (b[7:6] == 2'b10);
    unique case (rule_r)
      TR_A0_BF: trail_ok = trail_ok && (b >= 8'hA0);
      TR_80_9F: trail_ok = trail_ok && (b <= 8'h9F);
      TR_90_BF: trail_ok = trail_ok && (b >= 8'h90);
      TR_80_8F: trail_ok = trail_ok && (b <= 8'h8F);
      default:  trail_ok = trail_ok;
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    rule_nxt = rule_r;
    op       = OP_NONE;
    if (pend_r != 2'd0 && trail_ok) begin
      part_nxt = cp_ext;
      pend_nxt = pend_r - 2'd1;
      rule_nxt = TR_ANY;
      if (pend_r == 2'd1) begin
        op       = classify_cp(cp_ext);
        part_nxt = '0;
      end
    end else begin
      // broken sequence: drop it and restart on this byte
      pend_nxt = 2'd0;
      part_nxt = '0;
      rule_nxt = TR_ANY;
      priority if (b[7] == 1'b0) begin
        if (b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0D ||
            (b >= SEP_LO && b <= SEP_HI)) begin
          op = OP_CLEAR;
        end
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        pend_nxt = 2'd1;
        part_nxt = {16'd0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        pend_nxt = 2'd2;
        part_nxt = {17'd0, b[3:0]};
        rule_nxt = (b == 8'hE0) ? TR_A0_BF : (b == 8'hED) ? TR_80_9F : TR_ANY;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        pend_nxt = 2'd3;
        part_nxt = {18'd0, b[2:0]};
        rule_nxt = (b == 8'hF0) ? TR_90_BF : (b == 8'hF4) ? TR_80_8F : TR_ANY;
      end else begin
        pend_nxt = 2'd0;
      end
    end
  end

  assign q_push        = accept && (op != OP_NONE || in_ch.end_of_buffer);
  assign q_entry.op    = op;
  assign q_entry.last  = in_ch.end_of_buffer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      part_r <= '0;
      rule_r <= TR_ANY;
    end else if (accept) begin
      if (in_ch.end_of_buffer) begin
        pend_r <= 2'd0;
        part_r <= '0;
        rule_r <= TR_ANY;
      end else begin
        pend_r <= pend_nxt;
        part_r <= part_nxt;
        rule_r <= rule_nxt;
      end
    end
  end

endmodule

>>> rtl/ubec_queue.sv
// Short FIFO of stack operations between decoder and stack unit.
module ubec_queue
  import ubec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  stat
);

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ubec_stack.sv
// Back end: context stack kept as a depth count plus a stack of PDI positions.
module ubec_stack
  import ubec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_entry_t   head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output stk_stat_t  stat,
  ubec_out_if.source out_ch
);

  // positions of the PDI marks below the newest one
  logic [IDX_W-1:0] pos_mem [STACK_DEPTH];

  logic [CNT_W-1:0] ctx_r, ctx_nxt;
  logic [CNT_W-1:0] pdi_r, pdi_nxt;
  logic [IDX_W-1:0] top_r, top_nxt;
  logic [IDX_W-1:0] below_r;
  logic             ovf_r, ovf_nxt;
  logic             wr_en, push_pdi;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             top_is_pdf;
  logic             out_valid_r, unclosed_r, ovf_out_r;
  logic             stall_out;

  assign stall_out = head.last && out_valid_r && !out_ch.ready;
  assign pop       = !q_stat.empty && !stall_out;

  assign top_is_pdf = (ctx_r != '0) &&
                      ((pdi_r == '0) || ({1'b0, top_r} != ctx_r - 1'b1));

  always_comb begin
    ctx_nxt  = ctx_r;
    pdi_nxt  = pdi_r;
    top_nxt  = top_r;
    ovf_nxt  = ovf_r;
    push_pdi = 1'b0;
    if (pop) begin
      unique case (head.op)
        OP_PUSH_PDF: begin
          if (ctx_r < CNT_W'(STACK_DEPTH)) begin
            ctx_nxt = ctx_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_PUSH_PDI: begin
          if (ctx_r < CNT_W'(STACK_DEPTH)) begin
            push_pdi = 1'b1;
            ctx_nxt  = ctx_r + 1'b1;
            pdi_nxt  = pdi_r + 1'b1;
            top_nxt  = ctx_r[IDX_W-1:0];
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_POP_PDF: begin
          if (top_is_pdf) begin
            ctx_nxt = ctx_r - 1'b1;
          end
        end
        OP_POP_PDI: begin
          if (pdi_r != '0) begin
            ctx_nxt = {1'b0, top_r};
            pdi_nxt = pdi_r - 1'b1;
            top_nxt = below_r;
          end
        end
        OP_CLEAR: begin
          ctx_nxt = '0;
          pdi_nxt = '0;
        end
        default: begin
          ctx_nxt = ctx_r;
        end
      endcase
    end
  end

  assign wr_en   = push_pdi && (pdi_r != '0);
  assign wr_addr = IDX_W'(pdi_r - 1'b1);
  assign rd_addr = IDX_W'(pdi_nxt - CNT_W'(2));

  // a push writes the entry the read would target: forward the old top
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= top_r;
    end
    if (push_pdi) begin
      below_r <= top_r;
    end else begin
      below_r <= pos_mem[rd_addr];
    end
    top_r <= top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
      pdi_r <= '0;
      ovf_r <= 1'b0;
    end else if (pop && head.last) begin
      ctx_r <= '0;
      pdi_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      ctx_r <= ctx_nxt;
      pdi_r <= pdi_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      unclosed_r <= (ctx_nxt != '0);
      ovf_out_r  <= ovf_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.unclosed_context = unclosed_r;
  assign out_ch.stack_overflowed = ovf_out_r;
  assign stat.ctx_cnt            = ctx_r;
  assign stat.pdi_cnt            = pdi_r;

endmodule

>>> rtl/utf8_bidi_embedding_checker_top.sv
// Top level: UTF-8 bidi embedding checker (decoder, op queue, stack unit).
// Throughput: one byte per cycle while the op queue is not full; the stack
//   unit retires one op a cycle unless a final op waits on a busy output.
//   Result: the final op is queued, retired after ops ahead, then registered.
// Reset: rst_n synchronous, active low; clears decoder, queue and stack counts at
//   once. The PDI position memory needs no clearing pass.
`include "utf8_bidi_embedding_checker_top_assert.svh"

module utf8_bidi_embedding_checker_top
  import ubec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ubec_in_if.sink    in_ch,
  ubec_out_if.source out_ch
);

  // decoder -> queue
  logic      q_push;
  q_entry_t  q_in;
  // queue -> stack unit
  q_entry_t  q_head;
  q_stat_t   q_stat;
  logic      q_pop;
  stk_stat_t stk_stat;

  // Front: strict UTF-8 decode. Only bytes that finish a bidi code point or a
  // separator, plus the final byte of a buffer, produce a queue entry.
  ubec_decoder u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  // Two-entry op queue lets the stack unit stall on a busy output without
  // stopping byte intake at once.
  ubec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  // Back: stack depth counter plus a memory of PDI positions, so a PDI pop is
  // a single lookup instead of a search. Holds the result register.
  ubec_stack u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .stat   (stk_stat),
    .out_ch (out_ch)
  );

  `UBEC_ASSERT_NOW(a_no_q_overrun, q_stat.full, !q_push, "op queue written while full")
  `UBEC_ASSERT_NEXT(a_last_gives_result, q_pop && q_head.last, out_ch.valid, "no result after final op")
  `UBEC_ASSERT_NOW(a_pdi_le_ctx, 1'b1, stk_stat.pdi_cnt <= stk_stat.ctx_cnt, "PDI count exceeds depth")

endmodule

>>> sim/utf8_bidi_embedding_checker_top_test.sv
// Testbench for the UTF-8 bidi embedding checker: byte stream in, one verdict per buffer out.
module utf8_bidi_embedding_checker_top_test;
  import ubec_pkg::*;

  // Separator bytes that clear the context stack (besides SEP_LO..SEP_HI).
  localparam logic [7:0] TAB_BYTE = 8'h09;
  localparam logic [7:0] LF_BYTE  = 8'h0A;
  localparam logic [7:0] VT_BYTE  = 8'h0B;
  localparam logic [7:0] CR_BYTE  = 8'h0D;

  localparam int ITEM_TARGET   = 1350;  // stop offering once this many bytes went in
  localparam int CALM_AFTER    = 1150;  // no idling on either side past this point
  localparam int SQUEEZE_AFTER = 250;   // receiver starts its long hold here
  localparam int SQUEEZE_LEN   = 200;   // cycles of the long hold
  localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES  = 20;    // settle time once the last verdict is in
  localparam int DIRECTED_ROWS = 31;

  typedef struct packed {
    logic unclosed_context;
    logic stack_overflowed;
  } verdict_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_buffer;
    logic       pinned;       // verdict below is typed in, not predicted
    verdict_t   verdict;
  } stim_row_t;

  localparam verdict_t SHUT = '{1'b0, 1'b0};
  localparam verdict_t OPEN = '{1'b1, 1'b0};

  // Directed buffers, one byte per row. Only the first two verdicts are typed in;
  // the rest go through the predictor.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // single byte right after reset: nothing can be open
    '{8'h00, 1'b1, 1'b1, SHUT},
    // RLO, RLI, then PDF blocked by the isolate on top; ends on an invalid lead
    '{8'hE2, 1'b0, 1'b0, SHUT}, '{8'h80, 1'b0, 1'b0, SHUT}, '{8'hAE, 1'b0, 1'b0, SHUT},
    '{8'hE2, 1'b0, 1'b0, SHUT}, '{8'h81, 1'b0, 1'b0, SHUT}, '{8'hA7, 1'b0, 1'b0, SHUT},
    '{8'hE2, 1'b0, 1'b0, SHUT}, '{8'h80, 1'b0, 1'b0, SHUT}, '{8'hAC, 1'b0, 1'b0, SHUT},
    '{8'hFF, 1'b1, 1'b1, OPEN},
    // overlong lead cut off by a fresh lead, RLE, out-of-range 4-byte form,
    // PDF that pops, and a lead left dangling at the end of the buffer
    '{8'hE0, 1'b0, 1'b0, SHUT},
    '{8'hE2, 1'b0, 1'b0, SHUT}, '{8'h80, 1'b0, 1'b0, SHUT}, '{8'hAB, 1'b0, 1'b0, SHUT},
    '{8'hF4, 1'b0, 1'b0, SHUT}, '{8'h90, 1'b0, 1'b0, SHUT},
    '{8'hE2, 1'b0, 1'b0, SHUT}, '{8'h80, 1'b0, 1'b0, SHUT}, '{8'hAC, 1'b0, 1'b0, SHUT},
    '{8'hE2, 1'b1, 1'b0, SHUT},
    // LRI, LRE, PDI pops through both; separator byte closes the buffer
    '{8'hE2, 1'b0, 1'b0, SHUT}, '{8'h81, 1'b0, 1'b0, SHUT}, '{8'hA6, 1'b0, 1'b0, SHUT},
    '{8'hE2, 1'b0, 1'b0, SHUT}, '{8'h80, 1'b0, 1'b0, SHUT}, '{8'hAA, 1'b0, 1'b0, SHUT},
    '{8'hE2, 1'b0, 1'b0, SHUT}, '{8'h81, 1'b0, 1'b0, SHUT}, '{8'hA9, 1'b0, 1'b0, SHUT},
    '{8'h1C, 1'b1, 1'b0, SHUT}
  };

  logic clk = 1'b0;
  logic rst_n;

  ubec_in_if  in_ch ();
  ubec_out_if out_ch ();

  utf8_bidi_embedding_checker_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the decoder and the context stack.
  // ---------------------------------------------------------------------------
  bit          ctx_mark [STACK_DEPTH];  // 1 = isolate (closed by PDI), 0 = embedding
  int unsigned ctx_depth;
  int unsigned trail_left;
  logic [20:0] cp_acc;
  trail_rule_t trail_rule;
  bit          dropped_push;

  verdict_t    verdicts_due [$];        // verdicts owed by the block, oldest first
  logic [7:0]  buffer_bytes [$];        // bytes of the random buffer being built

  // Shared between the stimulus, receiver, monitor and watchdog processes.
  int          fail_count  = 0;
  int          items_sent  = 0;
  int          items_taken = 0;
  int          idle_cycles = 0;
  bit          calm        = 1'b0;
  bit          squeezing   = 1'b0;
  bit          tx_bursty   = 1'b1;
  logic        pin_on      = 1'b0;
  verdict_t    pin_verdict = SHUT;

  function automatic void forget_buffer();
    foreach (ctx_mark[k]) ctx_mark[k] = 1'b0;
    ctx_depth    = 0;
    trail_left   = 0;
    cp_acc       = '0;
    trail_rule   = TR_ANY;
    dropped_push = 1'b0;
  endfunction

  function automatic void push_ctx(input bit isolate);
    if (ctx_depth < STACK_DEPTH) begin
      ctx_mark[ctx_depth] = isolate;
      ctx_depth++;
    end else begin
      dropped_push = 1'b1;
    end
  endfunction

  function automatic void apply_cp(input logic [20:0] cp);
    int unsigned i;
    bit          hit;
    case (cp)
      CP_LRE, CP_RLE, CP_LRO, CP_RLO: push_ctx(1'b0);
      CP_LRI, CP_RLI, CP_FSI:         push_ctx(1'b1);
      CP_PDF: begin
        if (ctx_depth > 0 && !ctx_mark[ctx_depth-1]) ctx_depth--;
      end
      CP_PDI: begin
        // unwind down to and including the newest isolate, if any
        hit = 1'b0;
        for (i = ctx_depth; i > 0 && !hit; i--) begin
          if (ctx_mark[i-1]) begin
            ctx_depth = i - 1;
            hit = 1'b1;
          end
        end
      end
      CP_PSEP: ctx_depth = 0;
      default: ;
    endcase
  endfunction

  function automatic bit trail_fits(input logic [7:0] b);
    if (b < 8'h80 || b > 8'hBF) return 1'b0;
    case (trail_rule)
      TR_A0_BF: return b >= 8'hA0;
      TR_80_9F: return b <= 8'h9F;
      TR_90_BF: return b >= 8'h90;
      TR_80_8F: return b <= 8'h8F;
      default:  return 1'b1;
    endcase
  endfunction

  function automatic void lead_byte(input logic [7:0] b);
    if (b < 8'h80) begin
      if (b == TAB_BYTE || b == LF_BYTE || b == VT_BYTE || b == CR_BYTE ||
          (b >= SEP_LO && b <= SEP_HI))
        ctx_depth = 0;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      trail_left = 1;
      cp_acc     = {16'b0, b[4:0]};
      trail_rule = TR_ANY;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      trail_left = 2;
      cp_acc     = {17'b0, b[3:0]};
      if (b == 8'hE0)      trail_rule = TR_A0_BF;  // no overlong 3-byte
      else if (b == 8'hED) trail_rule = TR_80_9F;  // no surrogates
      else                 trail_rule = TR_ANY;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      trail_left = 3;
      cp_acc     = {18'b0, b[2:0]};
      if (b == 8'hF0)      trail_rule = TR_90_BF;  // no overlong 4-byte
      else if (b == 8'hF4) trail_rule = TR_80_8F;  // nothing above U+10FFFF
      else                 trail_rule = TR_ANY;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    if (trail_left != 0 && trail_fits(b)) begin
      cp_acc     = {cp_acc[14:0], b[5:0]};
      trail_left--;
      trail_rule = TR_ANY;
      if (trail_left == 0) begin
        apply_cp(cp_acc);
        cp_acc = '0;
      end
    end else begin
      // a broken sequence is dropped and the byte starts over as a lead
      trail_left = 0;
      cp_acc     = '0;
      trail_rule = TR_ANY;
      lead_byte(b);
    end
  endfunction

  function automatic verdict_t close_buffer();
    verdict_t v;
    v.unclosed_context = (ctx_depth != 0);
    v.stack_overflowed = dropped_push;
    forget_buffer();
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Random buffer builder.
  // ---------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] b);
    buffer_bytes.insert(buffer_bytes.size(), b);
  endfunction

  function automatic void put_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic [20:0] bidi_cp(input int k);
    case (k)
      0:       return CP_LRE;
      1:       return CP_RLE;
      2:       return CP_LRO;
      3:       return CP_RLO;
      4:       return CP_LRI;
      5:       return CP_RLI;
      6:       return CP_FSI;
      7:       return CP_PDF;
      8:       return CP_PDI;
      default: return CP_PSEP;
    endcase
  endfunction

  function automatic logic [7:0] rand_in(input int lo, input int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // Malformed or cut-short sequences, each aimed at one rejection path.
  function automatic void put_broken();
    case ($urandom_range(0, 7))
      0: add_byte(rand_in(8'h80, 8'hBF));
      1: begin
        add_byte(rand_in(8'hC0, 8'hC1));
        add_byte(rand_in(8'h80, 8'hBF));
      end
      2: begin
        add_byte(8'hE0);
        add_byte(rand_in(8'h80, 8'h9F));
        add_byte(rand_in(8'h80, 8'hBF));
      end
      3: begin
        add_byte(8'hED);
        add_byte(rand_in(8'hA0, 8'hBF));
        add_byte(rand_in(8'h80, 8'hBF));
      end
      4: begin
        add_byte(8'hF0);
        add_byte(rand_in(8'h80, 8'h8F));
      end
      5: begin
        add_byte(8'hF4);
        add_byte(rand_in(8'h90, 8'hBF));
      end
      6: add_byte(rand_in(8'hF5, 8'hFF));
      default: begin
        // lead plus fewer trail bytes than it needs
        add_byte(rand_in(8'hE1, 8'hF3));
        if ($urandom_range(0, 1)) add_byte(rand_in(8'h80, 8'hBF));
      end
    endcase
  endfunction

  function automatic void put_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      put_cp(bidi_cp($urandom_range(0, 9)));
    end else if (pick < 55) begin
      add_byte(rand_in(8'h00, 8'h7F));
    end else if (pick < 60) begin
      case ($urandom_range(0, 4))
        0:       add_byte(TAB_BYTE);
        1:       add_byte(LF_BYTE);
        2:       add_byte(VT_BYTE);
        3:       add_byte(CR_BYTE);
        default: add_byte(rand_in(SEP_LO, SEP_HI));
      endcase
    end else if (pick < 72) begin
      case ($urandom_range(0, 3))
        0:       put_cp(21'($urandom_range(32'h7FF, 32'h80)));
        1:       put_cp(21'($urandom_range(32'hD7FF, 32'h800)));
        2:       put_cp(21'($urandom_range(32'hFFFF, 32'hE000)));
        default: put_cp(21'($urandom_range(32'h10FFFF, 32'h10000)));
      endcase
    end else if (pick < 90) begin
      put_broken();
    end else begin
      add_byte(rand_in(8'h00, 8'hFF));
    end
  endfunction

  // Mostly short mixed buffers; now and then a push-heavy one that runs the
  // stack up to and past its depth.
  function automatic void plan_buffer(input int idx);
    int n;
    int pick;
    buffer_bytes.delete();
    if (idx % 50 == 7) begin
      n = $urandom_range(58, 80);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)     put_cp(CP_PDF);
        else if (pick < 5) put_cp(bidi_cp($urandom_range(0, 3)));
        else               put_cp(bidi_cp($urandom_range(4, 6)));
      end
      repeat ($urandom_range(0, 3)) put_token();
    end else begin
      repeat ($urandom_range(1, 12)) put_token();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one byte per call, with an optional idle burst ahead of it.
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input logic last, input logic pin,
                            input verdict_t v);
    if (!calm && !squeezing && tx_bursty && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.text_byte     <= b;
    in_ch.end_of_buffer <= last;
    pin_on              <= pin;
    pin_verdict         <= v;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm = 1'b1;
    // alternate between bursty and gap-free stretches
    if ($urandom_range(0, 149) == 0) tx_bursty = !tx_bursty;
  endtask

  initial begin
    int buffer_idx;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.text_byte     = '0;
    in_ch.end_of_buffer = 1'b0;
    forget_buffer();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      offer_byte(directed_rows[r].text_byte, directed_rows[r].end_of_buffer,
                 directed_rows[r].pinned, directed_rows[r].verdict);

    // Hold off until the block has handed back every verdict owed so far.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);

    buffer_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      plan_buffer(buffer_idx);
      foreach (buffer_bytes[k])
        offer_byte(buffer_bytes[k], k == buffer_bytes.size() - 1, 1'b0, SHUT);
      buffer_idx++;
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
    // a late, unrequested result would still show up here
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold to back the block up, and
  // steady ready once the run is winding down.
  // ---------------------------------------------------------------------------
  initial begin
    int  hold_left;
    bit  squeeze_done;
    bit  rx_bursty;
    out_ch.ready = 1'b0;
    hold_left    = 0;
    squeeze_done = 1'b0;
    rx_bursty    = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) rx_bursty = !rx_bursty;
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!squeeze_done && items_taken >= SQUEEZE_AFTER) begin
        // long hold: the sender keeps offering while results pile up
        out_ch.ready <= 1'b0;
        squeezing    <= 1'b1;
        hold_left     = SQUEEZE_LEN - 1;
        squeeze_done  = 1'b1;
      end else if (!calm && rx_bursty && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        hold_left     = $urandom_range(0, 9);
      end else begin
        out_ch.ready <= 1'b1;
        squeezing    <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted byte, check every accepted verdict.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.text_byte);
        items_taken <= items_taken + 1;
        if (in_ch.end_of_buffer) begin
          want = close_buffer();
          verdicts_due.insert(verdicts_due.size(), pin_on ? pin_verdict : want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.unclosed_context, out_ch.stack_overflowed};
        if (verdicts_due.size() == 0) begin
          $error("verdict with none pending: unclosed_context=%0b stack_overflowed=%0b",
                 got.unclosed_context, got.stack_overflowed);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (got.unclosed_context !== want.unclosed_context) begin
            $error("unclosed_context: expected %0b, got %0b",
                   want.unclosed_context, got.unclosed_context);
            fail_count++;
          end
          if (got.stack_overflowed !== want.stack_overflowed) begin
            $error("stack_overflowed: expected %0b, got %0b",
                   want.stack_overflowed, got.stack_overflowed);
            fail_count++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: too long without any handshake means the block has hung.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

endmodule
